// File: rtl/core/tal_pkg.sv
// Shared types and constants for the tracking area list parser.
package tal_pkg;

  // Default capacity of the decoded identity list.
  localparam int MAX_TAI_DEF = 16;

  // Depth of the command queue between the front and back parts.
  localparam int CMDQ_DEPTH = 2;

  // Width of counts and list positions; holds values up to 63.
  localparam int CNT_W = 6;

  // List type codes from bits 6..5 of a partial list header.
  localparam logic [1:0] KIND_SEPARATE = 2'd0;
  localparam logic [1:0] KIND_CONSEC   = 2'd1;

  // Byte position within the element.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NET0,
    PH_NET1,
    PH_NET2,
    PH_CODE0,
    PH_CODE1,
    PH_CODE2
  } phase_t;

  // One request from the front part: a run of identities, an end marker, or both.
  typedef struct packed {
    logic [23:0]      net;
    logic [23:0]      code;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] run;
    logic             done;
  } cmd_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [23:0] net;
    logic [23:0] code;
    logic [3:0]  index;
    logic        valid;
    logic        last_run;
    logic        done;
    logic [4:0]  total;
  } res_t;

endpackage

// File: rtl/core/tracking_area_list_parser.sv
// A result passes from the request queue through the expansion registers into the output register.
// Throughput: one byte per cycle while full is low; a byte that stores identities, or an
// end marker, holds the expansion unit until all its results are emitted, and full rises
// once the 2-entry request queue fills.
// Reset (synchronous, active low) clears the parser to idle, empties the request
// queue and the output register; the first byte may be pushed in the next cycle.
module tracking_area_list_parser #(
  parameter int MAX_TAI = tal_pkg::MAX_TAI_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_req,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_mcc_digit1,
  output logic [3:0]  out_mcc_digit2,
  output logic [3:0]  out_mcc_digit3,
  output logic [3:0]  out_mnc_digit1,
  output logic [3:0]  out_mnc_digit2,
  output logic [3:0]  out_mnc_digit3,
  output logic [23:0] out_area_code,
  output logic [3:0]  out_entry_index,
  output logic        out_entry_valid,
  output logic        out_last_of_run,
  output logic        out_list_done,
  output logic [4:0]  out_total_count
);

  logic          f_push;
  tal_pkg::cmd_t f_cmd;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  tal_pkg::cmd_t q_head;
  tal_pkg::res_t res;

  tal_front #(
    .MAX_TAI(MAX_TAI)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (push),
    .in_data_byte(in_data_byte),
    .in_start_req(in_start_req),
    .in_full     (full),
    .q_push      (f_push),
    .q_cmd       (f_cmd),
    .q_full      (q_full)
  );

  tal_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .push_cmd(f_cmd),
    .q_full  (q_full),
    .pop     (q_pop),
    .head_cmd(q_head),
    .q_empty (q_empty)
  );

  tal_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .res      (res),
    .out_empty(empty),
    .out_pop  (pop)
  );

  // Unpack the BCD network digits: mcc2:mcc1, mnc3:mcc3, mnc2:mnc1.
  assign out_mcc_digit1  = res.net[19:16];
  assign out_mcc_digit2  = res.net[23:20];
  assign out_mcc_digit3  = res.net[11:8];
  assign out_mnc_digit1  = res.net[3:0];
  assign out_mnc_digit2  = res.net[7:4];
  assign out_mnc_digit3  = res.net[15:12];
  assign out_area_code   = res.code;
  assign out_entry_index = res.index;
  assign out_entry_valid = res.valid;
  assign out_last_of_run = res.last_run;
  assign out_list_done   = res.done;
  assign out_total_count = res.total;

endmodule

// File: rtl/core/tal_front.sv
// Front part: parses element bytes and issues identity runs to the queue.
module tal_front #(
  parameter int MAX_TAI = tal_pkg::MAX_TAI_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_data_byte,
  input  logic          in_start_req,
  output logic          in_full,
  output logic          q_push,
  output tal_pkg::cmd_t q_cmd,
  input  logic          q_full
);

  localparam int CW = tal_pkg::CNT_W;

  tal_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      bytes_left_r, bytes_left_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [CW-1:0]   entries_r, entries_nxt;
  logic [23:0]     net_r, net_nxt;
  logic [23:0]     code_r, code_nxt;
  logic [CW-1:0]   stored_r, stored_nxt;

  logic          acc;
  logic          live;
  logic          last;
  logic          store_ev;
  logic [23:0]   code_full;
  logic [CW-1:0] run_req;
  logic [CW-1:0] room;
  logic [CW-1:0] run_n;

  // A byte is taken whenever the queue has room for what it may issue.
  assign in_full = q_full;
  assign acc     = in_push & ~q_full;

  // Classification of the current byte.
  assign live      = acc & ~in_start_req & (phase_r != tal_pkg::PH_IDLE) &
                     (bytes_left_r != 8'd0);
  assign last      = acc & (in_start_req ? (in_data_byte == 8'd0)
                                         : (live & (bytes_left_r == 8'd1)));
  assign store_ev  = live & (phase_r == tal_pkg::PH_CODE2);
  assign code_full = {code_r[23:8], in_data_byte};

  // Number of identities this byte stores, limited by the free list space.
  assign run_req = (kind_r == tal_pkg::KIND_CONSEC) ? entries_r : CW'(1);
  assign room    = CW'(MAX_TAI) - stored_r;
  assign run_n   = (run_req < room) ? run_req : room;

  // Request to the back part.
  assign q_push     = last | (store_ev & (run_n != '0));
  assign q_cmd.net  = net_r;
  assign q_cmd.code = code_full;
  assign q_cmd.idx  = in_start_req ? '0 : stored_r;
  assign q_cmd.run  = store_ev ? run_n : '0;
  assign q_cmd.done = last;

  // Datapath updates.
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    kind_nxt       = kind_r;
    entries_nxt    = entries_r;
    net_nxt        = net_r;
    code_nxt       = code_r;
    stored_nxt     = stored_r;
    if (acc && in_start_req) begin
      bytes_left_nxt = in_data_byte;
      kind_nxt       = 2'd0;
      entries_nxt    = '0;
      net_nxt        = '0;
      code_nxt       = '0;
      stored_nxt     = '0;
    end else if (live) begin
      bytes_left_nxt = bytes_left_r - 8'd1;
      unique case (phase_r)
        tal_pkg::PH_HEADER: begin
          kind_nxt    = in_data_byte[6:5];
          entries_nxt = CW'(in_data_byte[4:0]) + CW'(1);
          net_nxt     = '0;
        end
        tal_pkg::PH_NET0:  net_nxt  = {in_data_byte, 16'h0000};
        tal_pkg::PH_NET1:  net_nxt  = {net_r[23:16], in_data_byte, net_r[7:0]};
        tal_pkg::PH_NET2:  net_nxt  = {net_r[23:8], in_data_byte};
        tal_pkg::PH_CODE0: code_nxt = {in_data_byte, 16'h0000};
        tal_pkg::PH_CODE1: code_nxt = {code_r[23:16], in_data_byte, code_r[7:0]};
        tal_pkg::PH_CODE2: begin
          code_nxt    = code_full;
          stored_nxt  = stored_r + run_n;
          entries_nxt = (kind_r == tal_pkg::KIND_CONSEC) ? '0 : entries_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Next byte position.
  always_comb begin
    phase_nxt = phase_r;
    if (acc && in_start_req) begin
      phase_nxt = tal_pkg::PH_HEADER;
    end else if (live) begin
      unique case (phase_r)
        tal_pkg::PH_HEADER: phase_nxt = tal_pkg::PH_NET0;
        tal_pkg::PH_NET0:   phase_nxt = tal_pkg::PH_NET1;
        tal_pkg::PH_NET1:   phase_nxt = tal_pkg::PH_NET2;
        tal_pkg::PH_NET2:   phase_nxt = tal_pkg::PH_CODE0;
        tal_pkg::PH_CODE0:  phase_nxt = tal_pkg::PH_CODE1;
        tal_pkg::PH_CODE1:  phase_nxt = tal_pkg::PH_CODE2;
        tal_pkg::PH_CODE2: begin
          if (entries_nxt == '0) begin
            phase_nxt = tal_pkg::PH_HEADER;
          end else if (kind_r == tal_pkg::KIND_SEPARATE) begin
            phase_nxt = tal_pkg::PH_CODE0;
          end else begin
            phase_nxt = tal_pkg::PH_NET0;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
    // The element's final byte always returns to idle.
    if (last) begin
      phase_nxt = tal_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tal_pkg::PH_IDLE;
      bytes_left_r <= '0;
      kind_r       <= '0;
      entries_r    <= '0;
      net_r        <= '0;
      code_r       <= '0;
      stored_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      kind_r       <= kind_nxt;
      entries_r    <= entries_nxt;
      net_r        <= net_nxt;
      code_r       <= code_nxt;
      stored_r     <= stored_nxt;
    end
  end

endmodule

// File: rtl/core/tal_cmdq.sv
// Short request queue between the front and back parts.
module tal_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tal_pkg::cmd_t push_cmd,
  output logic          q_full,
  input  logic          pop,
  output tal_pkg::cmd_t head_cmd,
  output logic          q_empty
);

  localparam int DEPTH = tal_pkg::CMDQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  tal_pkg::cmd_t  slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign q_full   = (cnt_r == NW'(DEPTH));
  assign q_empty  = (cnt_r == '0);
  assign head_cmd = slots_r[rd_ptr_r];
  assign do_push  = push & ~q_full;
  assign do_pop   = pop & ~q_empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/tal_back.sv
// Back part: expands each request into results and holds the output register.
module tal_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tal_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output tal_pkg::res_t res,
  output logic          out_empty,
  input  logic          out_pop
);

  localparam int CW = tal_pkg::CNT_W;

  logic          act_r, act_nxt;
  logic [23:0]   net_r, net_nxt;
  logic [23:0]   code_r, code_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          done_r, done_nxt;
  logic          vld_r, vld_nxt;
  tal_pkg::res_t res_r, res_nxt;

  logic          slot_free;
  logic          emit;
  logic [CW-1:0] idx_inc;

  assign slot_free = ~vld_r | out_pop;
  assign q_pop     = ~act_r & ~q_empty;
  assign emit      = act_r & slot_free;
  assign idx_inc   = idx_r + CW'(1);
  assign res       = res_r;
  assign out_empty = ~vld_r;

  // Run expansion: one result per cycle while the output register has room.
  always_comb begin
    act_nxt  = act_r;
    net_nxt  = net_r;
    code_nxt = code_r;
    idx_nxt  = idx_r;
    left_nxt = left_r;
    done_nxt = done_r;
    res_nxt  = res_r;
    vld_nxt  = out_pop ? 1'b0 : vld_r;
    if (q_pop) begin
      act_nxt  = 1'b1;
      net_nxt  = q_cmd.net;
      code_nxt = q_cmd.code;
      idx_nxt  = q_cmd.idx;
      left_nxt = q_cmd.run;
      done_nxt = q_cmd.done;
    end else if (emit) begin
      vld_nxt = 1'b1;
      if (left_r == '0) begin
        // End marker: no identity stored by the final byte.
        res_nxt          = '0;
        res_nxt.last_run = 1'b1;
        res_nxt.done     = 1'b1;
        res_nxt.total    = idx_r[4:0];
        act_nxt          = 1'b0;
      end else begin
        res_nxt.net      = net_r;
        res_nxt.code     = code_r;
        res_nxt.index    = idx_r[3:0];
        res_nxt.valid    = 1'b1;
        res_nxt.last_run = (left_r == CW'(1));
        res_nxt.done     = done_r;
        res_nxt.total    = idx_inc[4:0];
        code_nxt         = code_r + 24'd1;
        idx_nxt          = idx_inc;
        left_nxt         = left_r - CW'(1);
        act_nxt          = (left_r != CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    net_r  <= net_nxt;
    code_r <= code_nxt;
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    done_r <= done_nxt;
    res_r  <= res_nxt;
  end

endmodule

// File: rtl/core/tal_checker.sv
// Port-level assertions for the tracking area list parser, bound to the top level.
module tal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [23:0] out_area_code,
  input logic [3:0]  out_entry_index,
  input logic        out_entry_valid,
  input logic        out_last_of_run,
  input logic        out_list_done,
  input logic [4:0]  out_total_count
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // A waiting result that is not popped stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_area_code) &&
                          $stable(out_entry_index) && $stable(out_total_count)))
    else $error("waiting result changed before pop");

  // An end marker carries no identity and closes the element.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_entry_valid) |->
      (out_list_done && out_last_of_run && out_area_code == 24'd0 &&
       out_entry_index == 4'd0))
    else $error("malformed end marker");

  // The running count of an identity is one past its position.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_entry_valid) |-> (out_total_count[3:0] == out_entry_index + 4'd1))
    else $error("count does not follow entry position");

endmodule

bind tracking_area_list_parser tal_checker u_tal_checker (.*);

// File: verif/tracking_area_list_parser_tb.sv
// Self-checking testbench for the tracking area identity list parser.
`timescale 1ns / 1ps

module tracking_area_list_parser_tb;

  localparam int MAX_TAI        = tal_pkg::MAX_TAI_DEF;
  localparam int RANDOM_ITEMS   = 240;
  localparam int CALM_ITEMS     = 40;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [7:0] byte_q_t[$];

  // One decoded tracking area identity, or an end marker.
  typedef struct packed {
    logic [3:0]  mcc1;
    logic [3:0]  mcc2;
    logic [3:0]  mcc3;
    logic [3:0]  mnc1;
    logic [3:0]  mnc2;
    logic [3:0]  mnc3;
    logic [23:0] tac;
    logic [3:0]  index;
    logic        valid;
    logic        last_run;
    logic        done;
    logic [4:0]  total;
  } tai_result_t;

  // Tracks the list element byte by byte and holds the identities still owed by the block.
  class tai_list_scoreboard;
    int unsigned      bytes_left;
    tal_pkg::phase_t  phase;
    logic [1:0]       kind;
    int               entries_left;
    logic [23:0]      net;
    logic [23:0]      code_acc;
    int               stored;
    tai_result_t      byte_run[$];
    tai_result_t      pending_tais[$];
    int               mismatches;

    function new();
      bytes_left   = 0;
      phase        = tal_pkg::PH_IDLE;
      kind         = tal_pkg::KIND_SEPARATE;
      entries_left = 0;
      net          = '0;
      code_acc     = '0;
      stored       = 0;
      mismatches   = 0;
    endfunction

    function int pending();
      return pending_tais.size();
    endfunction

    // Adds one identity to the current byte's run unless the list is full.
    function void emit_identity(logic [23:0] tac);
      tai_result_t r;
      if (stored >= MAX_TAI || byte_run.size() >= 32) return;
      r          = '0;
      r.mcc1     = net[19:16];
      r.mcc2     = net[23:20];
      r.mcc3     = net[11:8];
      r.mnc1     = net[3:0];
      r.mnc2     = net[7:4];
      r.mnc3     = net[15:12];
      r.tac      = tac;
      r.index    = stored[3:0];
      r.valid    = 1'b1;
      stored++;
      r.total    = stored[4:0];
      byte_run.push_back(r);
    endfunction

    // Advances the parse by one accepted byte and queues the identities it yields.
    function void decode_byte(logic [7:0] b, logic start);
      logic        last;
      tai_result_t r;
      int          i;
      byte_run = {};
      if (start) begin
        bytes_left   = b;
        stored       = 0;
        kind         = tal_pkg::KIND_SEPARATE;
        entries_left = 0;
        net          = '0;
        code_acc     = '0;
        phase        = tal_pkg::PH_HEADER;
        last         = (b == 8'd0);
      end else begin
        // Bytes outside an element are dropped without a trace.
        if (phase == tal_pkg::PH_IDLE || bytes_left == 0) return;
        bytes_left--;
        last = (bytes_left == 0);
        case (phase)
          tal_pkg::PH_HEADER: begin
            kind         = b[6:5];
            entries_left = b[4:0] + 1;
            net          = '0;
            phase        = tal_pkg::PH_NET0;
          end
          tal_pkg::PH_NET0: begin
            net   = {b, 16'h0000};
            phase = tal_pkg::PH_NET1;
          end
          tal_pkg::PH_NET1: begin
            net[15:8] = b;
            phase     = tal_pkg::PH_NET2;
          end
          tal_pkg::PH_NET2: begin
            net[7:0] = b;
            phase    = tal_pkg::PH_CODE0;
          end
          tal_pkg::PH_CODE0: begin
            code_acc = {b, 16'h0000};
            phase    = tal_pkg::PH_CODE1;
          end
          tal_pkg::PH_CODE1: begin
            code_acc[15:8] = b;
            phase          = tal_pkg::PH_CODE2;
          end
          default: begin
            code_acc[7:0] = b;
            // Consecutive codes expand from the base, wrapping at 24 bits.
            if (kind == tal_pkg::KIND_CONSEC) begin
              for (i = 0; i < entries_left; i++) emit_identity(code_acc + 24'(i));
              entries_left = 0;
            end else begin
              emit_identity(code_acc);
              if (entries_left > 0) entries_left--;
            end
            if (entries_left == 0) phase = tal_pkg::PH_HEADER;
            else if (kind == tal_pkg::KIND_SEPARATE) phase = tal_pkg::PH_CODE0;
            else phase = tal_pkg::PH_NET0;
          end
        endcase
      end

      // The element's final byte closes the list, with an end marker if it stored nothing.
      if (last) begin
        phase = tal_pkg::PH_IDLE;
        if (byte_run.size() == 0) begin
          r          = '0;
          r.last_run = 1'b1;
          r.done     = 1'b1;
          r.total    = stored[4:0];
          byte_run.push_back(r);
        end else begin
          foreach (byte_run[j]) byte_run[j].done = 1'b1;
        end
      end
      if (byte_run.size() > 0) byte_run[byte_run.size() - 1].last_run = 1'b1;
      foreach (byte_run[j]) pending_tais.push_back(byte_run[j]);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    // Compares one popped result against the oldest owed identity.
    function void check_identity(tai_result_t got);
      tai_result_t want;
      if (pending_tais.size() == 0) begin
        $error("result popped while none was owed (area code 0x%0h)", got.tac);
        mismatches++;
        return;
      end
      want = pending_tais.pop_front();
      compare_field("mcc_digit1", want.mcc1, got.mcc1);
      compare_field("mcc_digit2", want.mcc2, got.mcc2);
      compare_field("mcc_digit3", want.mcc3, got.mcc3);
      compare_field("mnc_digit1", want.mnc1, got.mnc1);
      compare_field("mnc_digit2", want.mnc2, got.mnc2);
      compare_field("mnc_digit3", want.mnc3, got.mnc3);
      compare_field("area_code", want.tac, got.tac);
      compare_field("entry_index", want.index, got.index);
      compare_field("entry_valid", want.valid, got.valid);
      compare_field("last_of_run", want.last_run, got.last_run);
      compare_field("list_done", want.done, got.done);
      compare_field("total_count", want.total, got.total);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic [7:0]  in_data_byte;
  logic        in_start_req;
  logic        full;
  logic        empty;
  logic        pop;
  logic [3:0]  out_mcc_digit1;
  logic [3:0]  out_mcc_digit2;
  logic [3:0]  out_mcc_digit3;
  logic [3:0]  out_mnc_digit1;
  logic [3:0]  out_mnc_digit2;
  logic [3:0]  out_mnc_digit3;
  logic [23:0] out_area_code;
  logic [3:0]  out_entry_index;
  logic        out_entry_valid;
  logic        out_last_of_run;
  logic        out_list_done;
  logic [4:0]  out_total_count;

  tai_list_scoreboard sb;
  bit                 idle_ok = 1'b0;
  int                 n_sent = 0;
  int                 rx_stall = 0;
  int                 quiet_cycles = 0;

  tracking_area_list_parser #(.MAX_TAI(MAX_TAI)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_data_byte    (in_data_byte),
    .in_start_req    (in_start_req),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .out_mcc_digit1  (out_mcc_digit1),
    .out_mcc_digit2  (out_mcc_digit2),
    .out_mcc_digit3  (out_mcc_digit3),
    .out_mnc_digit1  (out_mnc_digit1),
    .out_mnc_digit2  (out_mnc_digit2),
    .out_mnc_digit3  (out_mnc_digit3),
    .out_area_code   (out_area_code),
    .out_entry_index (out_entry_index),
    .out_entry_valid (out_entry_valid),
    .out_last_of_run (out_last_of_run),
    .out_list_done   (out_list_done),
    .out_total_count (out_total_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one byte, after an occasional idle burst, and holds the request until taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    in_start_req <= start;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.decode_byte(b, start);
    n_sent++;
  endtask

  // Sends a length octet and then the first n_send bytes of the body.
  task automatic send_element(input byte_q_t body, input int len, input int n_send);
    int i;
    send_byte(8'(len), 1'b1);
    for (i = 0; i < n_send; i++) send_byte(body[i], 1'b0);
  endtask

  // Holds off the sender until every owed result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check each popped result and stall pop in random bursts.
  always @(posedge clk) begin : result_side
    tai_result_t got;
    if (rst_n && pop && !empty) begin
      got.mcc1     = out_mcc_digit1;
      got.mcc2     = out_mcc_digit2;
      got.mcc3     = out_mcc_digit3;
      got.mnc1     = out_mnc_digit1;
      got.mnc2     = out_mnc_digit2;
      got.mnc3     = out_mnc_digit3;
      got.tac      = out_area_code;
      got.index    = out_entry_index;
      got.valid    = out_entry_valid;
      got.last_run = out_last_of_run;
      got.done     = out_list_done;
      got.total    = out_total_count;
      sb.check_identity(got);
    end
    if (rx_stall > 0) begin
      rx_stall--;
      pop <= 1'b0;
    end else if (idle_ok && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Counts cycles in which no request moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    byte_q_t    body;
    logic [1:0] kind;
    int         cnt;
    int         len;
    int         n_send;
    int         mode;
    int         stop_at;

    sb = new();
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_data_byte <= 8'h00;
    in_start_req <= 1'b0;
    pop          <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Element restarted in mid-network, then an element of zero length.
    body = {8'h00, 8'h12, 8'h34};
    send_element(body, 4, 3);
    send_byte(8'h00, 1'b1);

    // Consecutive codes with 32 entries from a base just below the wrap; storage
    // fills at the limit, and a stray byte follows past the stated length.
    body = {8'h3F, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFE, 8'hAB};
    send_element(body, 7, 8);

    // Separate codes with all-ones fields, then the reserved type with a two-digit network.
    body = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hE0, 8'h99, 8'hF9, 8'h10, 8'h00, 8'h00, 8'h00};
    send_element(body, 14, 14);

    wait_drained();

    // Random elements: mostly well formed, some truncated, restarted, padded or noise.
    stop_at = n_sent + RANDOM_ITEMS;
    while (n_sent < stop_at) begin
      idle_ok = (n_sent < stop_at - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      if (idle_ok && $urandom_range(0, 19) == 0) wait_drained();
      body = {};
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) body.push_back(8'($urandom()));
      end else begin
        do begin
          kind = 2'($urandom_range(0, 3));
          if (kind == tal_pkg::KIND_CONSEC) cnt = $urandom_range(0, 31);
          else if ($urandom_range(0, 7) == 0) cnt = $urandom_range(4, 17);
          else cnt = $urandom_range(0, 2);
          body.push_back({1'($urandom()), kind, 5'(cnt)});
          if (kind == tal_pkg::KIND_SEPARATE || kind == tal_pkg::KIND_CONSEC) begin
            repeat (3) body.push_back(8'($urandom()));
            if (kind == tal_pkg::KIND_CONSEC && $urandom_range(0, 3) == 0) begin
              // Base near the top so the expansion wraps.
              body.push_back(8'hFF);
              body.push_back(8'hFF);
              body.push_back(8'($urandom_range(224, 255)));
            end else begin
              repeat (kind == tal_pkg::KIND_CONSEC ? 3 : 3 * (cnt + 1))
                body.push_back(8'($urandom()));
            end
          end else begin
            repeat (6 * (cnt + 1)) body.push_back(8'($urandom()));
          end
        end while (body.size() < 100 && $urandom_range(0, 2) != 0);
      end

      len    = body.size();
      n_send = len;
      mode   = $urandom_range(0, 11);
      if (mode == 0) begin
        // Length ends inside the body.
        len    = $urandom_range(0, body.size() - 1);
        n_send = len;
      end else if (mode == 1) begin
        // Next element starts before this one is complete.
        n_send = $urandom_range(0, body.size() - 1);
      end else if (mode == 2) begin
        // Extra bytes after the stated length.
        repeat ($urandom_range(1, 3)) body.push_back(8'($urandom()));
        n_send = body.size();
      end
      send_element(body, len, n_send);
    end

    idle_ok = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tal_pkg.sv
rtl/core/tal_front.sv
rtl/core/tal_cmdq.sv
rtl/core/tal_back.sv
rtl/core/tracking_area_list_parser.sv
rtl/core/tal_checker.sv
verif/tracking_area_list_parser_tb.sv
